>>> hw/rtl/cbwm_pkg.sv
// ----------------------------------------------------------------------------
// cbwm_pkg
// Shared types and constants for the cartridge bank and work RAM overlay mapper.
// ----------------------------------------------------------------------------
package cbwm_pkg;

    localparam int PRG_ADDR_BITS_DEFAULT = 20;

    localparam int ROM_OFFSET_W = 20;
    localparam int RAM_OFFSET_W = 13;

    // Upper address nibbles that select the address-nibble decode modes
    localparam logic [3:0] NIB_A = 4'hA;
    localparam logic [3:0] NIB_C = 4'hC;
    localparam logic [3:0] NIB_D = 4'hD;
    localparam logic [3:0] NIB_E = 4'hE;

    typedef enum logic [1:0] {
        TGT_ROM  = 2'd0,
        TGT_RAM  = 2'd1,
        TGT_NONE = 2'd2
    } cbwm_target_t;

    typedef struct packed {
        logic [15:0] addr;
        logic [7:0]  data;
    } cbwm_latch_t;

    typedef struct packed {
        cbwm_target_t              target;
        logic [ROM_OFFSET_W-1:0]   rom_offset;
        logic [RAM_OFFSET_W-1:0]   ram_offset;
        logic                      ram_write;
        logic                      mirroring;
    } cbwm_result_t;

endpackage

>>> hw/rtl/cbwm_decode.sv
// ----------------------------------------------------------------------------
// cbwm_decode
// Maps one bus access to ROM, work RAM or unmapped from the current latches,
// and gives the latch values the access leaves behind.
// ----------------------------------------------------------------------------
module cbwm_decode #(
    parameter int PRG_ADDR_BITS = cbwm_pkg::PRG_ADDR_BITS_DEFAULT
) (
    input  logic                  variant,
    input  cbwm_pkg::cbwm_latch_t latch,
    input  logic                  mode,
    input  logic [15:0]           address,
    input  logic [7:0]            data,
    output cbwm_pkg::cbwm_latch_t latch_next,
    output cbwm_pkg::cbwm_result_t result
);
    import cbwm_pkg::*;

    localparam int RAW_W = 30;
    localparam logic [RAW_W-1:0] PrgMask = (RAW_W'(1) << PRG_ADDR_BITS) - RAW_W'(1);

    function automatic logic [RAW_W-1:0] page8(input logic [15:0] bank,
                                               input logic [15:0] a);
        return (RAW_W'(bank) << 13) | RAW_W'(a[12:0]);
    endfunction

    function automatic logic [RAW_W-1:0] page16(input logic [15:0] bank,
                                                input logic [15:0] a);
        return (RAW_W'(bank) << 14) | RAW_W'(a[13:0]);
    endfunction

    logic [15:0]      l;
    logic [7:0]       d;
    logic [15:0]      win;
    logic             low;
    logic             ram_hit;
    logic [15:0]      l_sh;
    logic [15:0]      wb;
    logic [1:0]       slot;
    logic [15:0]      slot_bank;
    logic [RAW_W-1:0] rom_raw;
    logic [RAW_W-1:0] rom_masked;

    assign l    = latch.addr;
    assign d    = latch.data;
    assign win  = address & 16'hE000;
    assign low  = address < 16'hC000;
    assign l_sh = {l[11:0], 4'b0000};
    assign wb   = (16'(d >> 3) & 16'h0006) | 16'h0008;
    assign slot = address[14:13];

    always_comb
    begin
        slot_bank = (16'(l >> 1) & ~16'h0001) | 16'(slot);
        if (slot == 2'd3)
        begin
            slot_bank = slot_bank | 16'(d & 8'h04) | ((d[2] && d[6]) ? 16'h0008 : 16'h0000);
        end
    end

    always_comb
    begin
        if (variant)
        begin
            case (l[15:12])
                NIB_A, NIB_C, NIB_E: ram_hit = win == ((l_sh & 16'h6000) | 16'h8000);
                NIB_D:               ram_hit = (win == ((l_sh & 16'h2000) | 16'h8000)) ||
                                               (win == ((l_sh & 16'h2000) | 16'hC000));
                default:             ram_hit = 1'b0;
            endcase
        end
        else
        begin
            ram_hit = (win == (wb << 12)) || (d[1] && (win == ((wb ^ 16'h0004) << 12)));
        end
    end

    always_comb
    begin
        if (variant)
        begin
            case (l[15:12])
                NIB_A:   rom_raw = low ? page16(l >> 1, address) : page8(16'h0000, address);
                NIB_C:   rom_raw = low ? page16(l >> 1, address)
                                       : page16((l >> 1) | 16'h0001, address);
                NIB_D:   rom_raw = page8(l, address);
                NIB_E:   rom_raw = low ? page16(l >> 1, address)
                                       : page16(l[8] ? ((l >> 1) | 16'h0007) : 16'h0000,
                                                address);
                default: rom_raw = low ? page16(l >> 1, address) : page16(16'h0000, address);
            endcase
        end
        else if (d[1])
        begin
            rom_raw = page8(l >> 1, address);
        end
        else if (d[3])
        begin
            rom_raw = page8(slot_bank, address);
        end
        else
        begin
            rom_raw = low ? page16(l >> 2, address) : page16(16'h0000, address);
        end
    end

    assign rom_masked = rom_raw & PrgMask;

    always_comb
    begin
        latch_next        = latch;
        result.target     = TGT_NONE;
        result.rom_offset = '0;
        result.ram_offset = '0;
        result.ram_write  = 1'b0;
        if (address[15])
        begin
            if (ram_hit)
            begin
                result.target     = TGT_RAM;
                result.ram_offset = address[12:0];
                result.ram_write  = mode;
            end
            else
            begin
                result.target     = TGT_ROM;
                result.rom_offset = rom_masked[ROM_OFFSET_W-1:0];
                // latch the ROM-window write; offset above uses the old mapping
                if (mode)
                begin
                    latch_next.addr = address;
                    latch_next.data = data;
                end
            end
        end
        result.mirroring = variant ? ~latch_next.addr[11] : ~latch_next.data[0];
    end

endmodule

>>> hw/rtl/cartridge_bank_and_wram_overlay_mapper_unit.sv
// ----------------------------------------------------------------------------
// cartridge_bank_and_wram_overlay_mapper_unit
// Bus access mapper: PRG ROM banking with a work RAM overlay and mirroring.
// ----------------------------------------------------------------------------
// Accepts one CPU bus access per clock and returns one result per access, in
// order. An access is captured in the input register, decoded against the
// address and data latches, and moves into the output register when that
// register is empty or being taken, so throughput is one access per cycle
// while out_ready stays high.
// The latches update as the access moves into the output register, which
// keeps each decode seeing the state left by the access just before it.
// The output register stalls on out_ready; the input register keeps taking
// accesses while it has room or the output moves.
module cartridge_bank_and_wram_overlay_mapper_unit #(
    parameter int PRG_ADDR_BITS = cbwm_pkg::PRG_ADDR_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              mode,
    input  logic [15:0]                       address,
    input  logic [7:0]                        data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        target,
    output logic [cbwm_pkg::ROM_OFFSET_W-1:0] rom_offset,
    output logic [cbwm_pkg::RAM_OFFSET_W-1:0] ram_offset,
    output logic                              ram_write,
    output logic                              mirroring
);
    import cbwm_pkg::*;

    logic         variant_reg;
    cbwm_latch_t  latch_reg;
    cbwm_latch_t  latch_next;
    logic         s1_valid_reg;
    logic         s1_mode_reg;
    logic [15:0]  s1_address_reg;
    logic [7:0]   s1_data_reg;
    logic         out_valid_reg;
    cbwm_result_t out_reg;
    cbwm_result_t result_next;
    logic         advance;

    assign advance   = !out_valid_reg || out_ready;
    assign in_ready  = !s1_valid_reg || advance;
    assign cfg_ready = 1'b1;

    cbwm_decode #(
        .PRG_ADDR_BITS(PRG_ADDR_BITS)
    ) u_decode (
        .variant    (variant_reg),
        .latch      (latch_reg),
        .mode       (s1_mode_reg),
        .address    (s1_address_reg),
        .data       (s1_data_reg),
        .latch_next (latch_next),
        .result     (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg   <= 1'b0;
            latch_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                variant_reg <= cfg_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
                if (s1_valid_reg)
                begin
                    latch_reg <= latch_next;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_mode_reg    <= mode;
            s1_address_reg <= address;
            s1_data_reg    <= data;
        end
        if (advance && s1_valid_reg)
        begin
            out_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = out_reg.target;
    assign rom_offset = out_reg.rom_offset;
    assign ram_offset = out_reg.ram_offset;
    assign ram_write  = out_reg.ram_write;
    assign mirroring  = out_reg.mirroring;

    // latches move only when an item enters the output register
    a_latch_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_valid_reg) |=> $stable(latch_reg))
        else $error("latches changed without an item moving");

    a_ram_write_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.ram_write |-> out_reg.target == TGT_RAM)
        else $error("RAM write reported outside a RAM window");

    a_unmapped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.target == TGT_NONE |->
            out_reg.rom_offset == '0 && out_reg.ram_offset == '0 && !out_reg.ram_write)
        else $error("unmapped access with nonzero offsets");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty output register");

endmodule
